[src/sitrd_pkg.sv]
`default_nettype none

package sitrd_pkg;

   // Radix limits and item sizes
   localparam int MAX_BASE   = 16;
   localparam int NUM_DIGITS = 32;
   localparam int DIV_STEPS  = 4;

   // Character codes
   localparam logic [7:0] SIGN_PLUS  = 8'h2B;
   localparam logic [7:0] SIGN_MINUS = 8'h2D;

   // Register indexes
   localparam logic [1:0] CSR_BASE_LENGTH  = 2'd0;
   localparam logic [1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [1:0] CSR_SYMBOLS_HIGH = 2'd2;

   // Register reset values
   localparam logic [4:0]  BASE_LENGTH_RESET  = 5'd10;
   localparam logic [63:0] SYMBOLS_LOW_RESET  = 64'h3736_3534_3332_3130;
   localparam logic [63:0] SYMBOLS_HIGH_RESET = 64'h0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic push;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic base_ok;
      logic negative;
      logic last_digit;
      logic one_left;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[src/signed_integer_to_radix_digits.sv]
`default_nettype none
// Flow: accept, the base check, then for each digit one dividend byte per cycle through the
//   radix divider, then one output byte per cycle when not stalled.
// Numbers are taken one at a time, D digits each (1 to 32), plus a minus sign if negative.
// A rejected base emits nothing for the number and returns to idle.
// Reset: synchronous; base returns to length 10 with symbols "01234567" and zero bytes
//   above, which is rejected until the symbols are written; output register empties.

module signed_integer_to_radix_digits (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire  [1:0]  csr_addr,
   input  wire  [63:0] csr_wdata,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] number
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] text_byte
   output logic        rsp_tlast    // last_byte
);
   import sitrd_pkg::*;

   cmd_type    cmd;
   status_type status;

   sitrd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sitrd_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

[src/sitrd_ctrl.sv]
`default_nettype none

module sitrd_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  sitrd_pkg::status_type status,
   output sitrd_pkg::cmd_type    cmd
);
   import sitrd_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] step_ff, step_in;

   // State and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            step_in    = 2'd0;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            step_in = 2'd0;
            if (status.base_ok) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            // One byte of the dividend per cycle, a digit pushed once every byte has been divided
            cmd.div_step = 1'b1;
            step_in      = step_ff + 2'd1;
            if (step_ff == 2'(DIV_STEPS - 1)) begin
               cmd.push = 1'b1;
               if (status.last_digit) begin
                  state_in = status.negative ? ST_SIGN : ST_EMIT;
               end
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Pop digits most significant first
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.one_left) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CHECK))
      else $error("accepted item did not start the base check");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && !status.base_ok) |=> req_tready)
      else $error("rejected base did not return to idle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |=> (step_ff == $past(step_ff) + 2'd1))
      else $error("divide step counter skipped");

endmodule

`default_nettype wire

[src/sitrd_dp.sv]
`default_nettype none

module sitrd_dp (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_we,
   input  wire  [1:0]            csr_addr,
   input  wire  [63:0]           csr_wdata,
   input  wire  [31:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   input  sitrd_pkg::cmd_type    cmd,
   output sitrd_pkg::status_type status
);
   import sitrd_pkg::*;

   logic [4:0]   base_length_ff;
   logic [63:0]  symbols_low_ff;
   logic [63:0]  symbols_high_ff;
   logic         base_ok_ff, base_ok_in;
   logic [127:0] symbols;

   logic [31:0]  work_ff, work_in;
   logic [3:0]   rem_ff;
   logic [4:0]   rem_next;
   logic         neg_ff;
   logic [5:0]   depth_ff;
   logic [3:0]   stack_ff [NUM_DIGITS];
   logic [4:0]   top_idx;

   logic         out_valid_ff;
   logic [7:0]   out_data_ff;
   logic         out_last_ff;

   assign symbols = {symbols_high_ff, symbols_low_ff};

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_length_ff  <= BASE_LENGTH_RESET;
         symbols_low_ff  <= SYMBOLS_LOW_RESET;
         symbols_high_ff <= SYMBOLS_HIGH_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_BASE_LENGTH:  base_length_ff  <= csr_wdata[4:0];
            CSR_SYMBOLS_LOW:  symbols_low_ff  <= csr_wdata;
            CSR_SYMBOLS_HIGH: symbols_high_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Check the symbol set: length, forbidden bytes, repeats
   always_comb begin
      logic [7:0] sym_i;
      base_ok_in = (base_length_ff >= 5'd2) && (base_length_ff <= 5'(MAX_BASE));
      for (int i = 0; i < MAX_BASE; i++) begin
         sym_i = symbols[8*i +: 8];
         if (5'(i) < base_length_ff) begin
            if (sym_i == 8'h00 || sym_i == SIGN_PLUS || sym_i == SIGN_MINUS) begin
               base_ok_in = 1'b0;
            end
            for (int j = i + 1; j < MAX_BASE; j++) begin
               if (5'(j) < base_length_ff && symbols[8*j +: 8] == sym_i) begin
                  base_ok_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ok_ff <= base_ok_in;
   end

   // Long division of one byte of the dividend by the radix
   always_comb begin
      logic [4:0] r;
      r       = {1'b0, rem_ff};
      work_in = {work_ff[23:0], 8'h00};
      for (int b = 0; b < 8; b++) begin
         r = {r[3:0], work_ff[31 - b]};
         if (r >= base_length_ff) begin
            r              = r - base_length_ff;
            work_in[7 - b] = 1'b1;
         end
      end
      rem_next = r;
   end

   // Dividend, remainder, sign and digit stack
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         work_ff <= req_tdata[31] ? (32'd0 - req_tdata) : req_tdata;
         neg_ff  <= req_tdata[31];
         rem_ff  <= 4'd0;
      end else if (cmd.div_step) begin
         work_ff <= work_in;
         rem_ff  <= cmd.push ? 4'd0 : rem_next[3:0];
      end
      if (cmd.div_step && cmd.push) begin
         stack_ff[depth_ff[4:0]] <= rem_next[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= 6'd0;
      end else if (cmd.load) begin
         depth_ff <= 6'd0;
      end else if (cmd.div_step && cmd.push) begin
         depth_ff <= depth_ff + 6'd1;
      end else if (cmd.emit_digit) begin
         depth_ff <= depth_ff - 6'd1;
      end
   end

   assign top_idx = 5'(depth_ff - 6'd1);

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_sign || cmd.emit_digit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Load the sign or the symbol of the digit on top of the stack
   always_ff @(posedge clock) begin
      if (cmd.emit_sign) begin
         out_data_ff <= SIGN_MINUS;
         out_last_ff <= 1'b0;
      end else if (cmd.emit_digit) begin
         out_data_ff <= symbols[{stack_ff[top_idx], 3'b000} +: 8];
         out_last_ff <= (depth_ff == 6'd1);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // Status back to the controller
   always_comb begin
      status.base_ok    = base_ok_ff;
      status.negative   = neg_ff;
      status.last_digit = (work_in == 32'd0) || (depth_ff == 6'(NUM_DIGITS - 1));
      status.one_left   = (depth_ff == 6'd1);
      status.out_free   = !out_valid_ff || rsp_tready;
   end

   assert property (@(posedge clock) disable iff (reset)
      depth_ff <= 6'(NUM_DIGITS))
      else $error("digit stack overflow");

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> (depth_ff != 6'd0))
      else $error("digit popped from an empty stack");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_digit) |-> (!out_valid_ff || rsp_tready))
      else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
